@@ rtl/text_console_writer_core_assert.svh @@
// Assertion macros used by the console writer controller.
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TCW_ASSERT_NOW(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("tcw assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define TCW_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("tcw assertion failed");

`endif

@@ rtl/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
`default_nettype none
package tcw_pkg;

  // command codes
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'h07;

  // row accumulator: 8-bit row plus a column carry of at most 3 lines at 80 columns
  localparam int ROW_ACC_W = 9;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic init_wr;
    logic clr_wr;
    logic div_step;
    logic scroll_setup;
    logic scroll_rd;
    logic scroll_wr;
    logic rd_capture;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic div_more;
    logic need_scroll;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/tcw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/tcw_ctrl.sv @@
// Controller state machine for the text console writer.
`default_nettype none
`include "text_console_writer_core_assert.svh"
module tcw_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [1:0]        in_command,
  input  wire tcw_pkg::dp_stat_t stat,
  output tcw_pkg::dp_cmd_t       cmd
);
  import tcw_pkg::*;

  typedef enum logic [8:0] {
    S_INIT = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_DIV  = 9'b000000100,
    S_SCRL = 9'b000001000,
    S_SRD  = 9'b000010000,
    S_SWR  = 9'b000100000,
    S_CLR  = 9'b001000000,
    S_RD   = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;

  assign s_tready = (state == S_IDLE);
  assign take     = s_tvalid && s_tready;

  // command decode
  always_comb begin
    cmd              = '0;
    cmd.take         = take;
    cmd.init_wr      = (state == S_INIT);
    cmd.clr_wr       = (state == S_CLR);
    cmd.div_step     = (state == S_DIV);
    cmd.scroll_setup = (state == S_SCRL);
    cmd.scroll_rd    = (state == S_SRD);
    cmd.scroll_wr    = (state == S_SWR);
    cmd.rd_capture   = (state == S_RD);
    cmd.out_load     = (state == S_FIN) && stat.out_free;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (take) begin
          case (in_command)
            CMD_CLEAR: state_next = S_CLR;
            CMD_READ:  state_next = S_RD;
            default:   state_next = S_DIV;
          endcase
        end
      end
      S_DIV: begin
        if (!stat.div_more) begin
          state_next = stat.need_scroll ? S_SCRL : S_FIN;
        end
      end
      S_SCRL: state_next = S_SRD;
      S_SRD:  state_next = S_SWR;
      S_SWR: begin
        state_next = stat.sweep_last ? S_FIN : S_SRD;
      end
      S_CLR: begin
        if (stat.sweep_last) state_next = S_DIV;
      end
      S_RD: state_next = S_FIN;
      S_FIN: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  `TCW_ASSERT_NEXT(a_take_leaves_idle, take, state != S_IDLE)
  `TCW_ASSERT_NEXT(a_fin_to_idle, (state == S_FIN) && stat.out_free, state == S_IDLE)
  `TCW_ASSERT_NEXT(a_scroll_read_then_write, state == S_SRD, state == S_SWR)
  `TCW_ASSERT_NOW(a_no_scroll_in_range, state == S_SCRL, stat.need_scroll)

endmodule
`default_nettype wire

@@ rtl/tcw_datapath.sv @@
// Datapath: cursor, screen memories, sweep counter and result register.
`default_nettype none
module tcw_datapath #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tcw_pkg::dp_cmd_t cmd,
  output tcw_pkg::dp_stat_t     stat,
  input  wire logic [1:0]       in_command,
  input  wire logic [7:0]       in_char,
  input  wire logic [7:0]       in_x,
  input  wire logic [7:0]       in_y,
  input  wire logic             cfg_we,
  input  wire logic [7:0]       cfg_wdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [6:0]            out_col,
  output logic [4:0]            out_line,
  output logic [7:0]            out_char,
  output logic [7:0]            out_attr
);
  import tcw_pkg::*;

  localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = $clog2(CELLS + 1);
  localparam int CW    = $clog2(SCREEN_COLS);
  localparam int LW    = $clog2(SCREEN_ROWS);
  localparam int NW    = LW + 1;
  localparam logic [AW-1:0] COLS_A = AW'(SCREEN_COLS);

  // cursor and place-cursor working registers
  logic [CW-1:0]        col_reg;
  logic [LW-1:0]        line_reg;
  logic [7:0]           xr;
  logic [ROW_ACC_W-1:0] row_acc;

  // sweep and scroll geometry
  logic [AW-1:0] sweep;
  logic [SW-1:0] shift;
  logic [SW-1:0] keep;

  // read result and config
  logic       rd_ok;
  logic [7:0] rd_char;
  logic [7:0] rd_attr;
  logic [7:0] text_attr;

  // memory ports
  logic          char_we;
  logic          attr_we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [7:0]    char_wdata;
  logic [7:0]    attr_wdata;
  logic [7:0]    char_dout;
  logic [7:0]    attr_dout;

  // combinational helpers
  logic                 is_newline;
  logic                 put_write;
  logic                 in_range;
  logic                 copy;
  logic [AW-1:0]        put_addr;
  logic [AW-1:0]        rd_addr_in;
  logic [AW-1:0]        src_addr;
  logic [ROW_ACC_W-1:0] excess;
  logic [NW-1:0]        lines;
  logic [SW-1:0]        shift_next;

  assign is_newline = (in_char == NEWLINE_CHAR);
  assign put_write  = cmd.take && (in_command == CMD_PUT) && !is_newline;
  assign in_range   = ({1'b0, in_x} < 9'(SCREEN_COLS)) && ({1'b0, in_y} < 9'(SCREEN_ROWS));
  assign put_addr   = AW'(col_reg) + AW'(line_reg) * COLS_A;
  assign rd_addr_in = AW'(in_x[CW-1:0]) + AW'(in_y[LW-1:0]) * COLS_A;

  // scroll amount, clamped to a full screen
  assign excess     = row_acc - ROW_ACC_W'(SCREEN_ROWS - 1);
  assign lines      = (excess >= ROW_ACC_W'(SCREEN_ROWS)) ? NW'(SCREEN_ROWS) : excess[NW-1:0];
  assign shift_next = SW'(lines) * SW'(SCREEN_COLS);
  assign copy       = SW'(sweep) < keep;
  assign src_addr   = AW'(SW'(sweep) + shift);

  // status
  assign stat.sweep_last  = (sweep == AW'(CELLS - 1));
  assign stat.div_more    = ({1'b0, xr} >= 9'(SCREEN_COLS));
  assign stat.need_scroll = (row_acc >= ROW_ACC_W'(SCREEN_ROWS));
  assign stat.out_free    = !m_tvalid || m_tready;

  // memory port muxing
  always_comb begin
    char_we = cmd.init_wr || cmd.clr_wr || cmd.scroll_wr || put_write;
    attr_we = cmd.init_wr || cmd.scroll_wr || put_write;
    waddr   = cmd.take ? put_addr : sweep;
    raddr   = cmd.scroll_rd ? (copy ? src_addr : sweep) : rd_addr_in;
    if (cmd.init_wr) begin
      char_wdata = 8'h00;
      attr_wdata = 8'h00;
    end else if (cmd.clr_wr) begin
      char_wdata = BLANK_CHAR;
      attr_wdata = text_attr;
    end else if (cmd.scroll_wr) begin
      char_wdata = copy ? char_dout : BLANK_CHAR;
      attr_wdata = copy ? attr_dout : text_attr;
    end else begin
      char_wdata = in_char;
      attr_wdata = text_attr;
    end
  end

  tcw_ram #(.WIDTH(8), .DEPTH(CELLS)) u_char_ram (
    .clk   (clk),
    .we    (char_we),
    .waddr (waddr),
    .wdata (char_wdata),
    .raddr (raddr),
    .rdata (char_dout)
  );

  tcw_ram #(.WIDTH(8), .DEPTH(CELLS)) u_attr_ram (
    .clk   (clk),
    .we    (attr_we),
    .waddr (waddr),
    .wdata (attr_wdata),
    .raddr (raddr),
    .rdata (attr_dout)
  );

  // attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr <= ATTR_RESET;
    end else if (cfg_we) begin
      text_attr <= cfg_wdata;
    end
  end

  // cursor, sweep, place-cursor, scroll geometry and read result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      col_reg  <= '0;
      line_reg <= '0;
      sweep    <= '0;
    end else begin
      if (cmd.take) begin
        sweep <= '0;
        rd_ok <= in_range && (in_command == CMD_READ);
        if (in_command != CMD_READ) begin
          rd_char <= 8'h00;
          rd_attr <= 8'h00;
        end
        case (in_command)
          CMD_PUT: begin
            if (is_newline) begin
              xr      <= 8'h00;
              row_acc <= ROW_ACC_W'(line_reg) + ROW_ACC_W'(1);
            end else begin
              xr      <= 8'(col_reg) + 8'd1;
              row_acc <= ROW_ACC_W'(line_reg);
            end
          end
          CMD_SET: begin
            xr      <= in_x;
            row_acc <= ROW_ACC_W'(in_y);
          end
          CMD_CLEAR: begin
            xr      <= 8'h00;
            row_acc <= '0;
          end
          default: ;
        endcase
      end

      // one column-wrap step per cycle
      if (cmd.div_step) begin
        if (stat.div_more) begin
          xr      <= xr - 8'(SCREEN_COLS);
          row_acc <= row_acc + ROW_ACC_W'(1);
        end else begin
          col_reg <= xr[CW-1:0];
          if (!stat.need_scroll) line_reg <= row_acc[LW-1:0];
        end
      end

      if (cmd.scroll_setup) begin
        shift    <= shift_next;
        keep     <= SW'(CELLS) - shift_next;
        line_reg <= LW'(SCREEN_ROWS - 1);
        sweep    <= '0;
      end

      if (cmd.init_wr || cmd.clr_wr || cmd.scroll_wr) begin
        sweep <= stat.sweep_last ? '0 : sweep + AW'(1);
      end

      if (cmd.rd_capture) begin
        rd_char <= rd_ok ? char_dout : 8'h00;
        rd_attr <= rd_ok ? attr_dout : 8'h00;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
      out_col  <= 7'(col_reg);
      out_line <= 5'(line_reg);
      out_char <= rd_char;
      out_attr <= rd_attr;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/text_console_writer_core.sv @@
// Text console writer: screen store, cursor and command handling.
// After reset an initial pass over all SCREEN_COLS*SCREEN_ROWS cells (2000) zeroes the store.
// Put char and newline pass the wrap state, read cell the capture state; the finish state loads the result word.
// Each column wrap (set cursor, put at the last column) adds a wrap step; clear blanks every char cell in a sweep.
// A scroll adds a setup step, then a sweep that reads then writes each cell.
// One command at a time, next one once the result register is free; rst is sync, active high.
`default_nettype none
module text_console_writer_core #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // char_code[7:0], x_pos[15:8], y_pos[23:16]
  input  wire logic [1:0]  s_tuser,   // command[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // cursor_col[6:0], cursor_line[11:7],
                                      // cell_char[19:12], cell_attr[27:20], zero fill
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);
  import tcw_pkg::*;

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [6:0] out_col;
  logic [4:0] out_line;
  logic [7:0] out_char;
  logic [7:0] out_attr;

  tcw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .in_command (s_tuser),
    .stat       (stat),
    .cmd        (cmd)
  );

  tcw_datapath #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_command (s_tuser),
    .in_char    (s_tdata[7:0]),
    .in_x       (s_tdata[15:8]),
    .in_y       (s_tdata[23:16]),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .out_col    (out_col),
    .out_line   (out_line),
    .out_char   (out_char),
    .out_attr   (out_attr)
  );

  // pack the result word
  assign m_tdata = {4'h0, out_attr, out_char, out_line, out_col};

endmodule
`default_nettype wire
